FILE: rtl/repeating_timer_table_assert.svh
// Assertion macros for the timer table RTL
`ifndef REPEATING_TIMER_TABLE_ASSERT_SVH
`define REPEATING_TIMER_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timer table assertion failed");
`define RTT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("timer table forbidden condition seen");
`else
`define RTT_ASSERT(lbl, clk, rst_n, prop)
`define RTT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/rtt_pkg.sv
// Types, operation codes and helpers for the repeating timer table
package rtt_pkg;

    localparam logic [3:0] OP_TICK       = 4'd0;
    localparam logic [3:0] OP_CREATE     = 4'd1;
    localparam logic [3:0] OP_KILL       = 4'd2;
    localparam logic [3:0] OP_PAUSE      = 4'd3;
    localparam logic [3:0] OP_RESUME     = 4'd4;
    localparam logic [3:0] OP_PAUSE_ALL  = 4'd5;
    localparam logic [3:0] OP_RESUME_ALL = 4'd6;
    localparam logic [3:0] OP_QUERY      = 4'd7;
    localparam logic [3:0] OP_KILL_ALL   = 4'd8;

    localparam logic CFG_TIME_SCALE   = 1'b0;
    localparam logic CFG_MIN_INTERVAL = 1'b1;

    localparam logic [15:0] TIME_SCALE_RESET   = 16'd256;
    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd66;

    // most negative remaining time (signed Q48.0, whole time units)
    localparam logic signed [47:0] REM_FLOOR = {1'b1, 47'd0};

    typedef enum logic [3:0] {
        S_IDLE,
        S_TSTART,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIRE,
        S_FREE,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        [15:0] handle;
        logic        [31:0] interval;
        logic signed [47:0] rem;
        logic signed [16:0] rep;
    } t_slot;

    typedef struct packed {
        logic [15:0] handle;
        logic [15:0] fires;
        logic [31:0] left;
        logic        act;
    } t_fire;

    function automatic logic [31:0] left_of(input logic signed [47:0] rem);
        return (rem <= 48'sd0) ? 32'd0 : rem[31:0];
    endfunction

endpackage

FILE: rtl/rtt_in_if.sv
// Operation channel of the timer table
interface rtt_in_if import rtt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic        [3:0]  operation;
    logic        [15:0] handle;
    logic        [31:0] amount;
    logic signed [16:0] repeat_count;

    modport source (output valid, operation, handle, amount, repeat_count, input ready);
    modport sink (input valid, operation, handle, amount, repeat_count, output ready);
endinterface

FILE: rtl/rtt_out_if.sv
// Result channel of the timer table
interface rtt_out_if import rtt_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] result_handle;
    logic        ok;
    logic [15:0] fired_times;
    logic        is_active;
    logic        is_paused;
    logic [31:0] time_left;
    logic [4:0]  active_count;
    logic        last;

    modport source (output valid, result_handle, ok, fired_times, is_active, is_paused,
                    time_left, active_count, last, input ready);
    modport sink (input valid, result_handle, ok, fired_times, is_active, is_paused,
                  time_left, active_count, last, output ready);
endinterface

FILE: rtl/rtt_ram.sv
// Simple dual-port RAM, one write and one registered read port
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

FILE: rtl/repeating_timer_table.sv
// Repeating timer table. Create, kill, pause, resume and query walk the slots through a
// slot memory with a registered read, stopping at the slot they need; pause all, resume
// all and kill all do not walk the slots. A tick, unless all timers are paused or its
// step is zero, walks the slots to update them, doing the catch-up fires of each due
// timer one after another (at most MAX_FIRES_PER_TICK per timer), frees killed slots,
// then walks the slots again to send the fire reports, which can stall on the output. A
// new operation is taken once the previous final result is in the output register.
module repeating_timer_table import rtt_pkg::*; #(
    parameter int NUM_TIMERS         = 16,
    parameter int MAX_FIRES_PER_TICK = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtt_in_if.sink     in_ch,
    rtt_out_if.source  out_ch,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    `include "repeating_timer_table_assert.svh"

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);
    localparam logic [16:0]   MAX_FIRES = 17'(MAX_FIRES_PER_TICK);

    t_state r_state, n_state;

    logic [NUM_TIMERS-1:0] r_used, r_paused, r_killed, r_repnz;
    logic                  r_all_paused;
    logic [15:0]           r_hcnt;
    logic [CW-1:0]         r_act_cnt;
    logic [15:0]           r_scale, r_min;

    logic [3:0]            r_op;
    logic [15:0]           r_handle;
    logic [31:0]           r_amount;
    logic signed [16:0]    r_rep_in;
    logic [39:0]           r_step;
    logic [IW-1:0]         r_idx;

    // timer being fired
    logic [15:0]           r_sh;
    logic [31:0]           r_iv;
    logic signed [47:0]    r_rem;
    logic signed [16:0]    r_rep;
    logic [15:0]           r_n;
    logic                  r_fdone;
    logic                  r_fkill;

    // final result of the operation
    logic [15:0]           r_rh;
    logic                  r_rok, r_ract, r_rpau;
    logic [31:0]           r_rleft;

    logic                  r_ov;
    logic [15:0]           r_o_handle, r_o_fired;
    logic                  r_o_ok, r_o_act, r_o_pau, r_o_last;
    logic [31:0]           r_o_left;
    logic [4:0]            r_o_cnt;

    t_slot s_q, sw_data;
    t_fire e_q, ew_data;
    logic  sw_en, ew_en, s_rd, e_rd;

    logic in_acc, can_load, load_en, is_last;
    logic used_i, killed_i, paused_i, repnz_i, elig, match, hit, is_tick, is_create;
    logic [47:0] prod, rem_off;
    logic signed [47:0] rem_sub, rem_add;
    logic sub_floor, f_due, fire_end, rep_pos, short_iv;
    logic signed [16:0] rep_dec;
    logic [15:0] hcnt_inc;
    logic [8:0] cnt_ext;

    rtt_ram #(.WIDTH($bits(t_slot)), .DEPTH(NUM_TIMERS)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (sw_en),
        .i_waddr(r_idx),
        .i_wdata(sw_data),
        .i_re   (s_rd),
        .i_raddr(r_idx),
        .o_rdata(s_q)
    );

    rtt_ram #(.WIDTH($bits(t_fire)), .DEPTH(NUM_TIMERS)) u_fire_ram (
        .i_clk  (i_clk),
        .i_we   (ew_en),
        .i_waddr(r_idx),
        .i_wdata(ew_data),
        .i_re   (e_rd),
        .i_raddr(r_idx),
        .o_rdata(e_q)
    );

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign can_load = !r_ov || out_ch.ready;
    assign is_last  = (r_idx == LAST_IDX);
    assign is_tick  = (r_op == OP_TICK);
    assign is_create = (r_op == OP_CREATE);
    assign used_i   = r_used[r_idx];
    assign killed_i = r_killed[r_idx];
    assign paused_i = r_paused[r_idx];
    assign repnz_i  = r_repnz[r_idx];
    assign elig     = used_i && !killed_i && !paused_i && repnz_i;
    assign match    = used_i && (s_q.handle == r_handle);
    assign hit      = is_create ? !used_i : match;
    assign prod     = in_ch.amount * r_scale;
    assign cnt_ext  = 9'(r_act_cnt);
    assign hcnt_inc = r_hcnt + 16'd1;

    // tick subtraction, saturating at the floor
    assign rem_off   = {~s_q.rem[47], s_q.rem[46:0]};
    assign sub_floor = rem_off < {8'd0, r_step};
    assign rem_sub   = sub_floor ? REM_FLOOR : (s_q.rem - $signed({8'd0, r_step}));

    // one catch-up fire per cycle
    assign f_due    = (r_rem <= 48'sd0) && ({1'b0, r_n} < MAX_FIRES);
    assign fire_end = r_fdone || !f_due;
    assign rep_pos  = (r_rep > 17'sd0);
    assign rep_dec  = r_rep - 17'sd1;
    assign rem_add  = r_rem + $signed({16'd0, r_iv});
    assign short_iv = (r_iv < {16'd0, r_min});

    assign load_en = (r_state == S_DONE) ||
                     ((r_state == S_EMIT_CHK) && (e_q.fires != 16'd0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_ch.operation)
                        OP_TICK: n_state = S_TSTART;
                        OP_CREATE, OP_KILL, OP_PAUSE, OP_RESUME, OP_QUERY: n_state = S_SCAN_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_TSTART: n_state = (r_all_paused || r_step == 40'd0) ? S_DONE : S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (is_tick) begin
                    n_state = elig ? S_FIRE : (is_last ? S_FREE : S_SCAN_RD);
                end else begin
                    n_state = (hit || is_last) ? S_DONE : S_SCAN_RD;
                end
            end
            S_FIRE: begin
                if (fire_end) begin
                    n_state = is_last ? S_FREE : S_SCAN_RD;
                end
            end
            S_FREE: n_state = S_EMIT_RD;
            S_EMIT_RD: n_state = S_EMIT_CHK;
            S_EMIT_CHK: begin
                if (e_q.fires == 16'd0 || can_load) begin
                    n_state = is_last ? S_DONE : S_EMIT_RD;
                end
            end
            S_DONE: n_state = can_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ch.ready = (r_state == S_IDLE);
        s_rd        = (r_state == S_SCAN_RD);
        e_rd        = (r_state == S_EMIT_RD);
        sw_en       = 1'b0;
        ew_en       = 1'b0;
        sw_data     = '{handle: r_sh, interval: r_iv, rem: r_rem, rep: r_rep};
        ew_data     = '{handle: r_sh, fires: r_n,
                        left: r_fkill ? 32'd0 : left_of(r_rem), act: !r_fkill};
        case (r_state)
            S_SCAN_CHK: begin
                if (is_create && !used_i) begin
                    sw_en   = 1'b1;
                    sw_data = '{handle: r_hcnt, interval: r_amount,
                                rem: $signed({16'd0, r_amount}), rep: r_rep_in};
                end
                if (is_tick && !elig) begin
                    ew_en   = 1'b1;
                    ew_data = '{handle: 16'd0, fires: 16'd0, left: 32'd0, act: 1'b0};
                end
            end
            S_FIRE: begin
                sw_en = fire_end;
                ew_en = fire_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_paused     <= '0;
            r_killed     <= '0;
            r_repnz      <= '0;
            r_all_paused <= 1'b0;
            r_hcnt       <= 16'd1;
            r_act_cnt    <= '0;
            r_scale      <= TIME_SCALE_RESET;
            r_min        <= MIN_INTERVAL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TIME_SCALE:   r_scale <= i_cfg_data;
                    CFG_MIN_INTERVAL: r_min   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= in_ch.operation;
                        r_handle <= in_ch.handle;
                        r_amount <= in_ch.amount;
                        r_rep_in <= in_ch.repeat_count;
                        r_step   <= prod[47:8];
                        r_idx    <= '0;
                        r_ract   <= 1'b0;
                        r_rpau   <= 1'b0;
                        r_rleft  <= 32'd0;
                        case (in_ch.operation)
                            OP_KILL, OP_PAUSE, OP_RESUME, OP_QUERY: begin
                                r_rh  <= in_ch.handle;
                                r_rok <= 1'b0;
                            end
                            OP_PAUSE_ALL: begin
                                r_all_paused <= 1'b1;
                                r_rh         <= 16'd0;
                                r_rok        <= 1'b1;
                            end
                            OP_RESUME_ALL: begin
                                r_all_paused <= 1'b0;
                                r_rh         <= 16'd0;
                                r_rok        <= 1'b1;
                            end
                            OP_KILL_ALL: begin
                                r_killed  <= r_used;
                                r_act_cnt <= '0;
                                r_rh      <= 16'd0;
                                r_rok     <= 1'b1;
                            end
                            default: begin
                                r_rh  <= 16'd0;
                                r_rok <= 1'b0;
                            end
                        endcase
                    end
                end
                S_TSTART: begin
                    r_rok <= !(r_all_paused || r_step == 40'd0);
                end
                S_SCAN_CHK: begin
                    if (is_tick) begin
                        if (elig) begin
                            r_sh    <= s_q.handle;
                            r_iv    <= s_q.interval;
                            r_rem   <= rem_sub;
                            r_rep   <= s_q.rep;
                            r_n     <= 16'd0;
                            r_fdone <= 1'b0;
                            r_fkill <= 1'b0;
                        end else if (!is_last) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (hit) begin
                        case (r_op)
                            OP_CREATE: begin
                                r_used[r_idx]   <= 1'b1;
                                r_paused[r_idx] <= 1'b0;
                                r_killed[r_idx] <= 1'b0;
                                r_repnz[r_idx]  <= (r_rep_in != 17'sd0);
                                if (r_rep_in != 17'sd0) begin
                                    r_act_cnt <= r_act_cnt + 1'b1;
                                end
                                r_hcnt  <= (hcnt_inc == 16'd0) ? 16'd1 : hcnt_inc;
                                r_rh    <= r_hcnt;
                                r_rok   <= 1'b1;
                                r_ract  <= (r_rep_in != 17'sd0);
                                r_rleft <= r_amount;
                            end
                            OP_KILL: begin
                                r_killed[r_idx] <= 1'b1;
                                if (!killed_i && repnz_i) begin
                                    r_act_cnt <= r_act_cnt - 1'b1;
                                end
                                r_rok  <= 1'b1;
                                r_rpau <= paused_i;
                            end
                            OP_PAUSE, OP_RESUME: begin
                                if (!killed_i) begin
                                    r_paused[r_idx] <= (r_op == OP_PAUSE);
                                    r_rpau  <= (r_op == OP_PAUSE);
                                    r_rok   <= 1'b1;
                                    r_ract  <= repnz_i;
                                    r_rleft <= left_of(s_q.rem);
                                end else begin
                                    r_rpau <= paused_i;
                                end
                            end
                            default: begin
                                r_rok   <= 1'b1;
                                r_rpau  <= paused_i;
                                r_ract  <= !killed_i && repnz_i;
                                r_rleft <= killed_i ? 32'd0 : left_of(s_q.rem);
                            end
                        endcase
                    end else if (!is_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIRE: begin
                    if (fire_end) begin
                        if (!is_last) begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_n <= r_n + 16'd1;
                        if (rep_pos) begin
                            r_rep <= rep_dec;
                        end
                        if (rep_pos && rep_dec == 17'sd0) begin
                            // repeats ran out: kill, leave remaining as it is
                            r_fkill         <= 1'b1;
                            r_fdone         <= 1'b1;
                            r_killed[r_idx] <= 1'b1;
                            r_act_cnt       <= r_act_cnt - 1'b1;
                        end else if (short_iv) begin
                            r_rem   <= $signed({16'd0, r_iv});
                            r_fdone <= 1'b1;
                        end else begin
                            r_rem <= rem_add;
                        end
                    end
                end
                S_FREE: begin
                    r_used   <= r_used & ~r_killed;
                    r_paused <= r_paused & ~(r_used & r_killed);
                    r_killed <= '0;
                    r_idx    <= '0;
                end
                S_EMIT_CHK: begin
                    if ((e_q.fires == 16'd0 || can_load) && !is_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_en && can_load) begin
            r_ov <= 1'b1;
        end else if (out_ch.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && can_load) begin
            r_o_cnt <= cnt_ext[4:0];
            if (r_state == S_DONE) begin
                r_o_handle <= r_rh;
                r_o_ok     <= r_rok;
                r_o_fired  <= 16'd0;
                r_o_act    <= r_ract;
                r_o_pau    <= r_rpau;
                r_o_left   <= r_rleft;
                r_o_last   <= 1'b1;
            end else begin
                r_o_handle <= e_q.handle;
                r_o_ok     <= 1'b1;
                r_o_fired  <= e_q.fires;
                r_o_act    <= e_q.act;
                r_o_pau    <= 1'b0;
                r_o_left   <= e_q.left;
                r_o_last   <= 1'b0;
            end
        end
    end

    assign out_ch.valid         = r_ov;
    assign out_ch.result_handle = r_o_handle;
    assign out_ch.ok            = r_o_ok;
    assign out_ch.fired_times   = r_o_fired;
    assign out_ch.is_active     = r_o_act;
    assign out_ch.is_paused     = r_o_pau;
    assign out_ch.time_left     = r_o_left;
    assign out_ch.active_count  = r_o_cnt;
    assign out_ch.last          = r_o_last;

    `RTT_NEVER(a_cnt_range, i_clk, i_rst_n, cnt_ext > 9'(NUM_TIMERS))
    `RTT_NEVER(a_killed_used, i_clk, i_rst_n, |(r_killed & ~r_used))
    `RTT_NEVER(a_paused_used, i_clk, i_rst_n, |(r_paused & ~r_used))
    `RTT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> !in_ch.ready)
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the repeating timer table: directed and random operations against a predictor
module testbench;
    import rtt_pkg::*;

    localparam int  SLOTS     = 16;
    localparam int  FIRE_CAP  = 1024;
    localparam int  LIMIT     = 20_000_000;
    localparam int  SETTLE    = 80;
    localparam longint FLOOR  = -(64'sd1 <<< 47);

    typedef struct {
        logic [15:0] handle;
        logic        ok;
        logic [15:0] fires;
        logic        act;
        logic        paused;
        logic [31:0] left;
        logic [4:0]  count;
        logic        last;
    } t_report;

    class timer_scoreboard;
        bit          used [SLOTS];
        logic [15:0] hnd [SLOTS];
        logic [31:0] ival [SLOTS];
        longint      rem [SLOTS];
        int          reps [SLOTS];
        bit          pau [SLOTS];
        bit          dead [SLOTS];
        bit          frozen;
        logic [15:0] next_handle;
        logic [15:0] scale;
        logic [15:0] min_ival;
        logic [15:0] made;
        t_report     pending [$];
        int          errors;

        function void restart();
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0; pau[i] = 0; dead[i] = 0;
            end
            frozen = 0;
            next_handle = 16'd1;
            scale = TIME_SCALE_RESET;
            min_ival = MIN_INTERVAL_RESET;
            errors = 0;
        endfunction

        function int find(logic [15:0] h);
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && hnd[i] == h) return i;
            return -1;
        endfunction

        function logic [4:0] live_count();
            int n = 0;
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && !dead[i] && reps[i] != 0) n++;
            return n[4:0];
        endfunction

        function logic [31:0] left_time(int s);
            if (dead[s] || rem[s] <= 0) return 32'd0;
            return rem[s][31:0];
        endfunction

        function void status(logic [15:0] h, logic ok, int s);
            t_report r;
            r = '{h, ok, 16'd0, 1'b0, 1'b0, 32'd0, live_count(), 1'b1};
            if (s >= 0) begin
                r.act = !dead[s] && reps[s] != 0;
                r.paused = pau[s];
                r.left = left_time(s);
            end
            pending.insert(pending.size(), r);
        endfunction

        function int advance(int i, longint step);
            int n = 0;
            longint r = rem[i];
            if (r - FLOOR < step) r = FLOOR;
            else r = r - step;
            while (r <= 0 && n < FIRE_CAP) begin
                n++;
                if (reps[i] > 0) begin
                    reps[i]--;
                    if (reps[i] == 0) begin
                        dead[i] = 1;
                        break;
                    end
                end
                r = r + longint'(ival[i]);
                if (ival[i] < {16'd0, min_ival}) begin
                    r = longint'(ival[i]);
                    break;
                end
            end
            rem[i] = r;
            return n;
        endfunction

        function void tick(logic [31:0] amount);
            longint step;
            int fired [SLOTS];
            logic [4:0] cnt;
            t_report r;
            step = longint'((64'(amount) * 64'(scale)) >> 8);
            if (frozen || step == 0) begin
                r = '{16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 32'd0, live_count(), 1'b1};
                pending.insert(pending.size(), r);
                return;
            end
            for (int i = 0; i < SLOTS; i++) begin
                fired[i] = 0;
                if (used[i] && !dead[i] && !pau[i] && reps[i] != 0)
                    fired[i] = advance(i, step);
            end
            // free killed slots once the walk is done
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && dead[i]) begin
                    used[i] = 0; dead[i] = 0; pau[i] = 0;
                end
            cnt = live_count();
            for (int i = 0; i < SLOTS; i++) begin
                if (fired[i] == 0) continue;
                r = '{hnd[i], 1'b1, (fired[i] > 65535) ? 16'hFFFF : fired[i][15:0],
                      1'b0, 1'b0, 32'd0, cnt, 1'b0};
                if (used[i]) begin
                    r.act = !dead[i] && reps[i] != 0;
                    r.paused = pau[i];
                    r.left = left_time(i);
                end
                pending.insert(pending.size(), r);
            end
            r = '{16'd0, 1'b1, 16'd0, 1'b0, 1'b0, 32'd0, cnt, 1'b1};
            pending.insert(pending.size(), r);
        endfunction

        function void note(logic [3:0] op, logic [15:0] h, logic [31:0] amount,
                           logic signed [16:0] rc);
            int s;
            made = 16'd0;
            case (op)
                OP_TICK: tick(amount);
                OP_CREATE: begin
                    for (s = 0; s < SLOTS && used[s]; s++) ;
                    if (s >= SLOTS) begin
                        status(16'd0, 1'b0, -1);
                    end else begin
                        used[s] = 1; hnd[s] = next_handle; ival[s] = amount;
                        rem[s] = longint'(amount); reps[s] = int'(rc);
                        pau[s] = 0; dead[s] = 0;
                        made = next_handle;
                        next_handle = next_handle + 16'd1;
                        if (next_handle == 16'd0) next_handle = 16'd1;
                        status(hnd[s], 1'b1, s);
                    end
                end
                OP_KILL: begin
                    s = find(h);
                    if (s >= 0) dead[s] = 1;
                    status(h, s >= 0, s);
                end
                OP_PAUSE, OP_RESUME: begin
                    s = find(h);
                    if (s >= 0 && !dead[s]) begin
                        pau[s] = (op == OP_PAUSE);
                        status(h, 1'b1, s);
                    end else begin
                        status(h, 1'b0, s);
                    end
                end
                OP_PAUSE_ALL, OP_RESUME_ALL: begin
                    frozen = (op == OP_PAUSE_ALL);
                    status(16'd0, 1'b1, -1);
                end
                OP_QUERY: begin
                    s = find(h);
                    status(h, s >= 0, s);
                end
                OP_KILL_ALL: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i]) dead[i] = 1;
                    status(16'd0, 1'b1, -1);
                end
                default: status(16'd0, 1'b0, -1);
            endcase
        endfunction

        function void check(t_report got);
            t_report w;
            if (pending.size() == 0) begin
                $error("result with nothing expected: handle %0d", got.handle);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.handle !== w.handle) begin
                $error("result_handle: expected %0d, got %0d", w.handle, got.handle); errors++;
            end
            if (got.ok !== w.ok) begin
                $error("ok: expected %0d, got %0d", w.ok, got.ok); errors++;
            end
            if (got.fires !== w.fires) begin
                $error("fired_times: expected %0d, got %0d", w.fires, got.fires); errors++;
            end
            if (got.act !== w.act) begin
                $error("is_active: expected %0d, got %0d", w.act, got.act); errors++;
            end
            if (got.paused !== w.paused) begin
                $error("is_paused: expected %0d, got %0d", w.paused, got.paused); errors++;
            end
            if (got.left !== w.left) begin
                $error("time_left: expected %0h, got %0h", w.left, got.left); errors++;
            end
            if (got.count !== w.count) begin
                $error("active_count: expected %0d, got %0d", w.count, got.count); errors++;
            end
            if (got.last !== w.last) begin
                $error("last: expected %0d, got %0d", w.last, got.last); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          cycles;
    int          send_gap;
    int          recv_gap;
    logic [15:0] known [$];

    timer_scoreboard sb;
    rtt_in_if  in_ch ();
    rtt_out_if out_ch ();

    repeating_timer_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: stall at random, check every transfer
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(99) >= recv_gap);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check('{out_ch.result_handle, out_ch.ok, out_ch.fired_times, out_ch.is_active,
                       out_ch.is_paused, out_ch.time_left, out_ch.active_count, out_ch.last});
    end

    task automatic send_op(logic [3:0] op, logic [15:0] h, logic [31:0] amount,
                           logic signed [16:0] rc);
        while ($urandom_range(99) < send_gap) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.operation = op;
        in_ch.handle = h;
        in_ch.amount = amount;
        in_ch.repeat_count = rc;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note(op, h, amount, rc);
        if (sb.made != 16'd0) known.insert(known.size(), sb.made);
        if (known.size() > 40) void'(known.pop_front());
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        if (idx == CFG_TIME_SCALE) sb.scale = value;
        else sb.min_ival = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_handle();
        if (known.size() != 0 && $urandom_range(9) < 8)
            return known[$urandom_range(known.size() - 1)];
        return $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
    endfunction

    task automatic random_op();
        int dice = $urandom_range(99);
        logic [31:0] amt;
        logic signed [16:0] rc;
        if (dice < 35) begin
            amt = ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 32'h2_0000);
            send_op(OP_TICK, 16'($urandom), amt, 17'($urandom));
        end else if (dice < 57) begin
            case ($urandom_range(9))
                0:       amt = $urandom;
                1, 2:    amt = $urandom_range(0, 120);
                default: amt = $urandom_range(1, 32'h4_0000);
            endcase
            rc = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 6)) - 17'sd1;
            send_op(OP_CREATE, 16'($urandom), amt, rc);
        end else if (dice < 65) send_op(OP_KILL, pick_handle(), $urandom, 17'($urandom));
        else if (dice < 72) send_op(OP_PAUSE, pick_handle(), $urandom, 17'($urandom));
        else if (dice < 80) send_op(OP_RESUME, pick_handle(), $urandom, 17'($urandom));
        else if (dice < 90) send_op(OP_QUERY, pick_handle(), $urandom, 17'($urandom));
        else if (dice < 92) send_op(OP_PAUSE_ALL, 16'($urandom), $urandom, 17'($urandom));
        else if (dice < 96) send_op(OP_RESUME_ALL, 16'($urandom), $urandom, 17'($urandom));
        else if (dice < 98) send_op(OP_KILL_ALL, 16'($urandom), $urandom, 17'($urandom));
        else send_op(4'($urandom_range(9, 15)), 16'($urandom), $urandom, 17'($urandom));
    endtask

    initial begin
        logic [15:0] scales [4];
        logic [15:0] mins [4];
        sb = new();
        sb.restart();
        cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.handle = 16'd0;
        in_ch.amount = 32'd0;
        in_ch.repeat_count = 17'sd0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: field extremes, every operation, the special cases
        send_op(OP_CREATE, 16'hFFFF, 32'd0, 17'sd0);            // zero repeats: never fires
        send_op(OP_CREATE, 16'd0, 32'hFFFF_FFFF, 17'sd65535);
        send_op(OP_CREATE, 16'd0, 32'd1, -17'sd1);              // below minimum interval
        send_op(OP_CREATE, 16'd0, 32'h0001_0000, -17'sd65536);
        send_op(OP_CREATE, 16'd0, 32'h0000_8000, 17'sd2);       // runs out after two fires
        send_op(OP_TICK, 16'd0, 32'd0, 17'sd0);                 // zero step: ignored
        send_op(OP_PAUSE_ALL, 16'd0, 32'd0, 17'sd0);
        send_op(OP_TICK, 16'd0, 32'h0002_0000, 17'sd0);         // globally paused: ignored
        send_op(OP_RESUME_ALL, 16'd0, 32'd0, 17'sd0);
        send_op(OP_PAUSE, 16'd4, 32'd0, 17'sd0);
        send_op(OP_TICK, 16'd0, 32'h0003_0000, 17'sd0);
        send_op(OP_RESUME, 16'd4, 32'd0, 17'sd0);
        send_op(OP_QUERY, 16'd0, 32'd0, 17'sd0);
        send_op(OP_QUERY, 16'd2, 32'd0, 17'sd0);
        send_op(OP_KILL, 16'd2, 32'd0, 17'sd0);
        send_op(OP_KILL, 16'd2, 32'd0, 17'sd0);                 // already killed
        send_op(OP_PAUSE, 16'd2, 32'd0, 17'sd0);                // killed: fails
        send_op(OP_TICK, 16'd0, 32'hFFFF_FFFF, 17'sd0);         // fire cap and catch-up
        for (int i = 0; i < 17; i++)                             // fill the table; the last creates find it full
            send_op(OP_CREATE, 16'd0, 32'h0000_4000 + 32'(i), -17'sd1);
        send_op(OP_KILL_ALL, 16'd0, 32'd0, 17'sd0);
        send_op(4'd15, 16'hFFFF, 32'hFFFF_FFFF, -17'sd1);
        send_op(OP_TICK, 16'd0, 32'd1, 17'sd0);
        drain();

        scales = '{16'd256, 16'd0, 16'hFFFF, 16'd64};
        mins   = '{16'd66, 16'hFFFF, 16'd0, 16'd1000};
        for (int phase = 0; phase < 3; phase++) begin
            send_gap = (phase == 0) ? 6 : (phase == 1) ? 65 : 0;
            recv_gap = (phase == 0) ? 65 : (phase == 1) ? 6 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                write_reg(CFG_TIME_SCALE, (phase == 2 && sub == 1) ? 16'($urandom)
                                          : scales[(phase * 2 + sub) % 4]);
                write_reg(CFG_MIN_INTERVAL, mins[(phase * 2 + sub + 1) % 4]);
                for (int n = 0; n < 48; n++) begin
                    random_op();
                    // hold off until the table has answered everything
                    if (n == 24) drain();
                end
                drain();
            end
        end

        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
